[src/rlm_pkg.sv]
// shared types, constants and byte helpers for the record literal matcher
`timescale 1ns / 1ps

package rlm_pkg;

  localparam int PATTERN_MAX_DEF = 32;
  localparam int REG_W           = 64;
  localparam int PAT_REGS        = 4;
  localparam int REG_BYTES       = 32;
  localparam int LEN_REG_W       = 6;
  localparam int CFG_INDEX_W     = 3;
  localparam int IDX_W           = 8;

  localparam logic [7:0] UNDERSCORE = 8'h5F;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_0     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_1     = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_2     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_3     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH        = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_WORD_MODE     = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_WHOLE_RECORD  = 3'd6;

  typedef logic [PAT_REGS-1:0][REG_W-1:0] pattern_t;

  function automatic logic is_word_byte(input logic [7:0] c);
    logic res;
    res = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
          (c >= 8'h61 && c <= 8'h7A) || (c == UNDERSCORE);
    return res;
  endfunction

  // bytes past the register bank read as zero
  function automatic logic [7:0] pat_byte(input pattern_t p, input logic [IDX_W-1:0] idx);
    logic [7:0] res;
    if (idx < IDX_W'(REG_BYTES)) begin
      res = p[idx[4:3]][{idx[2:0], 3'b000} +: 8];
    end else begin
      res = 8'h00;
    end
    return res;
  endfunction

endpackage

[src/record_literal_matcher.sv]
// record literal matcher: byte stream in, one match flag per record out
//
//   channel  direction  handshake            payload
//   in       to block   in_valid / in_stall  data_byte, has_byte, last_of_record
//   out      from block out_valid / out_stall record_matched
//   cfg      to block   cfg_we               cfg_index, cfg_data
//
// one item per cycle when not stalled; out_valid rises the cycle after a record end
// is processed; the work for a byte is one pass through the window compare between
// the input register and the result register
// rst is synchronous and clears control state and configuration
// a stalled result holds only a record end behind it; plain bytes keep flowing
`timescale 1ns / 1ps

module record_literal_matcher #(
  parameter int PATTERN_MAX = rlm_pkg::PATTERN_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         data_byte,
  input  logic                               has_byte,
  input  logic                               last_of_record,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               record_matched,
  input  logic                               cfg_we,
  input  logic [rlm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rlm_pkg::REG_W-1:0]          cfg_data
);

  localparam int LEN_W  = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W  = $clog2(PATTERN_MAX + 2);
  localparam int SKIP_W = $clog2(PATTERN_MAX);
  localparam int IDX_W  = rlm_pkg::IDX_W;

  // configuration
  rlm_pkg::pattern_t                pattern;
  logic [rlm_pkg::LEN_REG_W-1:0]    pattern_length;
  logic                             word_mode;
  logic                             whole_record_mode;

  // input register
  logic       hold_valid;
  logic [7:0] hold_byte;
  logic       hold_has;
  logic       hold_last;

  // record state
  logic [7:0]        recent [PATTERN_MAX+1];
  logic [CNT_W-1:0]  bytes_seen;
  logic [SKIP_W-1:0] skip_remaining;
  logic              candidate_pending;
  logic              found_flag;

  logic [CNT_W-1:0]  bytes_seen_next;
  logic [SKIP_W-1:0] skip_remaining_next;
  logic              candidate_pending_next;
  logic              found_flag_next;

  logic [7:0]        win [PATTERN_MAX+1];
  logic [LEN_W-1:0]  len;
  logic [CNT_W-1:0]  seen_upd;
  logic              window_eq;
  logic              before_ok;
  logic              matched;
  logic              go;

  assign go       = hold_valid && !(hold_last && out_valid && out_stall);
  assign in_stall = hold_valid && !go;

  always_comb begin
    if (int'(pattern_length) > PATTERN_MAX) begin
      len = LEN_W'(PATTERN_MAX);
    end else begin
      len = LEN_W'(pattern_length);
    end
  end

  // window after this byte, index 0 newest
  always_comb begin
    for (int k = 0; k <= PATTERN_MAX; k++) begin
      if (hold_has) begin
        win[k] = (k == 0) ? hold_byte : recent[(k == 0) ? 0 : k - 1];
      end else begin
        win[k] = recent[k];
      end
    end
  end

  always_comb begin
    if (hold_has && bytes_seen != CNT_W'(PATTERN_MAX + 1)) begin
      seen_upd = bytes_seen + CNT_W'(1);
    end else begin
      seen_upd = bytes_seen;
    end
  end

  always_comb begin
    window_eq = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      if (IDX_W'(k) < IDX_W'(len) &&
          win[k] != rlm_pkg::pat_byte(pattern, IDX_W'(len) - IDX_W'(k) - IDX_W'(1))) begin
        window_eq = 1'b0;
      end
    end
  end

  assign before_ok = !word_mode || (IDX_W'(seen_upd) == IDX_W'(len)) ||
                     !rlm_pkg::is_word_byte(win[len]);

  always_comb begin
    bytes_seen_next        = seen_upd;
    skip_remaining_next    = skip_remaining;
    candidate_pending_next = candidate_pending;
    found_flag_next        = found_flag;
    matched                = 1'b0;

    if (hold_has) begin
      if (len == '0) begin
        if (!(word_mode && ((bytes_seen != '0 && rlm_pkg::is_word_byte(recent[0])) ||
                            rlm_pkg::is_word_byte(hold_byte)))) begin
          found_flag_next = 1'b1;
        end
      end else if (candidate_pending) begin
        if (!(word_mode && rlm_pkg::is_word_byte(hold_byte))) begin
          found_flag_next = 1'b1;
        end
        candidate_pending_next = 1'b0;
      end

      if (len != '0) begin
        if (skip_remaining != '0) begin
          skip_remaining_next = skip_remaining - SKIP_W'(1);
        end else if (IDX_W'(seen_upd) >= IDX_W'(len) && window_eq) begin
          skip_remaining_next = SKIP_W'(len - LEN_W'(1));
          if (before_ok) begin
            if (word_mode) begin
              candidate_pending_next = 1'b1;
            end else begin
              found_flag_next = 1'b1;
            end
          end
        end
      end
    end

    if (hold_last) begin
      if (len == '0) begin
        if (!word_mode || seen_upd == '0 || !rlm_pkg::is_word_byte(win[0])) begin
          found_flag_next = 1'b1;
        end
      end else if (candidate_pending_next) begin
        found_flag_next = 1'b1;
      end

      if (whole_record_mode) begin
        matched = (IDX_W'(seen_upd) == IDX_W'(len)) && window_eq;
      end else begin
        matched = found_flag_next;
      end

      bytes_seen_next        = '0;
      skip_remaining_next    = '0;
      candidate_pending_next = 1'b0;
      found_flag_next        = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern           <= '0;
      pattern_length    <= '0;
      word_mode         <= 1'b0;
      whole_record_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index) inside
        rlm_pkg::REG_PATTERN_0, rlm_pkg::REG_PATTERN_1,
        rlm_pkg::REG_PATTERN_2, rlm_pkg::REG_PATTERN_3: begin
          pattern[cfg_index[1:0]] <= cfg_data;
        end
        rlm_pkg::REG_LENGTH: begin
          pattern_length <= cfg_data[rlm_pkg::LEN_REG_W-1:0];
        end
        rlm_pkg::REG_WORD_MODE: begin
          word_mode <= cfg_data[0];
        end
        rlm_pkg::REG_WHOLE_RECORD: begin
          whole_record_mode <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid        <= 1'b0;
      out_valid         <= 1'b0;
      bytes_seen        <= '0;
      skip_remaining    <= '0;
      candidate_pending <= 1'b0;
      found_flag        <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        hold_valid <= 1'b1;
      end else if (go) begin
        hold_valid <= 1'b0;
      end

      if (go) begin
        bytes_seen        <= bytes_seen_next;
        skip_remaining    <= skip_remaining_next;
        candidate_pending <= candidate_pending_next;
        found_flag        <= found_flag_next;
      end

      if (go && hold_last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_byte <= data_byte;
      hold_has  <= has_byte;
      hold_last <= last_of_record;
    end
    if (go && hold_has) begin
      for (int k = 0; k <= PATTERN_MAX; k++) begin
        recent[k] <= win[k];
      end
    end
    if (go && hold_last) begin
      record_matched <= matched;
    end
  end

  // input held back only by a record end waiting on a full result register
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (hold_valid && hold_last && out_valid && out_stall))
    else $error("input stalled without a blocked record end");

  // record state starts clean after every record end transfer
  assert property (@(posedge clk) disable iff (rst)
    (go && hold_last) |=> (bytes_seen == '0 && skip_remaining == '0 &&
                           !candidate_pending && !found_flag))
    else $error("record state not cleared after record end");

  assert property (@(posedge clk) disable iff (rst)
    int'(bytes_seen) <= PATTERN_MAX + 1)
    else $error("byte count past saturation");

endmodule

[tb/sv/record_literal_matcher_tb.sv]
// self-checking testbench for the record literal matcher: directed and random records
`timescale 1ns / 1ps

module record_literal_matcher_tb;

  localparam int ITEM_GOAL  = 1850;
  localparam int MAX_CYCLES = 3000000;
  localparam int DRAIN      = 8;

  typedef bit [rlm_pkg::REG_W-1:0] pat_regs_t [rlm_pkg::PAT_REGS];

  class record_match_board;
    bit [rlm_pkg::REG_W-1:0] pat [rlm_pkg::PAT_REGS];
    bit [rlm_pkg::LEN_REG_W-1:0] len_reg;
    bit word_only;
    bit whole_only;
    bit [7:0] recent [rlm_pkg::PATTERN_MAX_DEF+1];
    int unsigned seen;
    int unsigned skip_left;
    bit hit_waiting;
    bit hit_seen;
    bit flags_due [$];
    int unsigned errors;

    function new();
      foreach (pat[i]) pat[i] = '0;
      len_reg = '0;
      word_only = 1'b0;
      whole_only = 1'b0;
      errors = 0;
      clear_record();
    endfunction

    function void set_reg(logic [rlm_pkg::CFG_INDEX_W-1:0] idx,
                          logic [rlm_pkg::REG_W-1:0] v);
      case (idx) inside
        rlm_pkg::REG_PATTERN_0, rlm_pkg::REG_PATTERN_1,
        rlm_pkg::REG_PATTERN_2, rlm_pkg::REG_PATTERN_3: pat[idx[1:0]] = v;
        rlm_pkg::REG_LENGTH: len_reg = v[rlm_pkg::LEN_REG_W-1:0];
        rlm_pkg::REG_WORD_MODE: word_only = v[0];
        rlm_pkg::REG_WHOLE_RECORD: whole_only = v[0];
        default: ;
      endcase
    endfunction

    function bit word_char(bit [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
             (c >= "a" && c <= "z") || c == "_";
    endfunction

    function bit [7:0] pat_at(int unsigned i);
      if (i >= rlm_pkg::REG_BYTES) return 8'h00;
      return pat[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // newest n bytes equal the first n pattern bytes
    function bit tail_equals(int unsigned n);
      for (int unsigned k = 0; k < n; k++) begin
        if (recent[k] != pat_at(n - 1 - k)) return 1'b0;
      end
      return 1'b1;
    endfunction

    function void clear_record();
      foreach (recent[i]) recent[i] = 8'h00;
      seen = 0;
      skip_left = 0;
      hit_waiting = 1'b0;
      hit_seen = 1'b0;
    endfunction

    function void take_item(bit [7:0] b, bit has, bit last);
      int unsigned len;
      bit before_ok;
      bit flag;
      len = (len_reg > rlm_pkg::PATTERN_MAX_DEF) ? rlm_pkg::PATTERN_MAX_DEF : len_reg;
      if (has) begin
        if (len == 0) begin
          if (!(word_only && ((seen > 0 && word_char(recent[0])) || word_char(b))))
            hit_seen = 1'b1;
        end else if (hit_waiting) begin
          if (!(word_only && word_char(b))) hit_seen = 1'b1;
          hit_waiting = 1'b0;
        end
        for (int k = rlm_pkg::PATTERN_MAX_DEF; k > 0; k--) recent[k] = recent[k-1];
        recent[0] = b;
        if (seen < rlm_pkg::PATTERN_MAX_DEF + 1) seen++;
        if (len > 0) begin
          if (skip_left > 0) begin
            skip_left--;
          end else if (seen >= len && tail_equals(len)) begin
            before_ok = !word_only || seen == len || !word_char(recent[len]);
            skip_left = len - 1;
            if (before_ok) begin
              if (word_only) hit_waiting = 1'b1;
              else hit_seen = 1'b1;
            end
          end
        end
      end
      if (!last) return;
      if (len == 0) begin
        if (!word_only || seen == 0 || !word_char(recent[0])) hit_seen = 1'b1;
      end else if (hit_waiting) begin
        hit_seen = 1'b1;
      end
      if (whole_only) flag = seen == len && tail_equals(len);
      else flag = hit_seen;
      flags_due = {flags_due, flag};
      clear_record();
    endfunction

    function void check_flag(logic got);
      bit want;
      if (flags_due.size() == 0) begin
        $error("record_matched: expected none, got %0d", got);
        errors++;
        return;
      end
      want = flags_due.pop_front();
      if (got !== want) begin
        $error("record_matched: expected %0d, got %0d", want, got);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return flags_due.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] data_byte = 8'h00;
  logic has_byte = 1'b0;
  logic last_of_record = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic record_matched;
  logic cfg_we = 1'b0;
  logic [rlm_pkg::CFG_INDEX_W-1:0] cfg_index = rlm_pkg::REG_PATTERN_0;
  logic [rlm_pkg::REG_W-1:0] cfg_data = '0;

  record_match_board sb;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned stall_left = 0;
  bit quiet_in = 1'b0;
  bit quiet_out = 1'b0;
  pat_regs_t cur_pat;
  int unsigned cur_len = 0;
  bit cur_whole = 1'b0;

  record_literal_matcher dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .has_byte(has_byte),
    .last_of_record(last_of_record),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .record_matched(record_matched),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("record_literal_matcher_tb: errors");
      $finish;
    end
  end

  // result side: check each transfer, then draw the next stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        sb.check_flag(record_matched);
        stall_left = quiet_out ? 0 : $urandom_range(0, 16);
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input bit [7:0] d, input bit has, input bit last);
    int unsigned gap;
    gap = quiet_in ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    has_byte <= has;
    last_of_record <= last;
    do @(posedge clk); while (in_stall);
    sb.take_item(d, has, last);
    if (has || last) items_sent++;
  endtask

  task automatic program_matcher(input pat_regs_t p,
                                 input bit [rlm_pkg::LEN_REG_W-1:0] plen,
                                 input bit wm, input bit wrm);
    logic [rlm_pkg::CFG_INDEX_W-1:0] regs [7];
    logic [rlm_pkg::REG_W-1:0] vals [7];
    regs = '{rlm_pkg::REG_PATTERN_0, rlm_pkg::REG_PATTERN_1, rlm_pkg::REG_PATTERN_2,
             rlm_pkg::REG_PATTERN_3, rlm_pkg::REG_LENGTH, rlm_pkg::REG_WORD_MODE,
             rlm_pkg::REG_WHOLE_RECORD};
    vals = '{p[0], p[1], p[2], p[3], rlm_pkg::REG_W'(plen), rlm_pkg::REG_W'(wm),
             rlm_pkg::REG_W'(wrm)};
    for (int i = 0; i < 7; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= regs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      sb.set_reg(regs[i], vals[i]);
    end
    cfg_we <= 1'b0;
    cur_pat = p;
    cur_len = (plen > rlm_pkg::PATTERN_MAX_DEF) ? rlm_pkg::PATTERN_MAX_DEF : plen;
    cur_whole = wrm;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_text(input string s);
    if (s.len() == 0) begin
      send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b1, i == s.len() - 1);
    end
  endtask

  function automatic bit [7:0] text_byte();
    case ($urandom_range(0, 11))
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "0";
      4: return "9";
      5: return "_";
      6: return " ";
      7: return ".";
      8: return "Z";
      9: return "z";
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_random_record();
    bit [7:0] body [$];
    int unsigned parts;
    bit tail;
    if (cur_whole && $urandom_range(0, 1) == 1) begin
      for (int unsigned i = 0; i < cur_len; i++)
        body = {body, cur_pat[i / 8][(i % 8) * 8 +: 8]};
      if ($urandom_range(0, 2) == 0 && body.size() > 0)
        body[$urandom_range(0, body.size() - 1)] = text_byte();
    end else begin
      parts = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 5);
      repeat (parts) begin
        if ($urandom_range(0, 2) == 0) begin
          for (int unsigned i = 0; i < cur_len; i++)
            body = {body, cur_pat[i / 8][(i % 8) * 8 +: 8]};
        end else begin
          body = {body, text_byte()};
        end
      end
    end
    tail = body.size() == 0 || $urandom_range(0, 3) == 0;
    foreach (body[i]) begin
      if ($urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(body[i], 1'b1, !tail && i == body.size() - 1);
    end
    if (tail) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  initial begin
    pat_regs_t p;
    bit [rlm_pkg::LEN_REG_W-1:0] plen;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: empty pattern, plain search
    send_text("");
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    wait_idle();

    // empty pattern in word mode
    p = '{64'h0, 64'h0, 64'h0, 64'h0};
    program_matcher(p, 6'd0, 1'b1, 1'b0);
    send_text("a");
    send_text("a ");
    wait_idle();

    // word boundaries around a short literal
    p = '{64'h6261, 64'h0, 64'h0, 64'h0};
    program_matcher(p, 6'd2, 1'b1, 1'b0);
    send_text("ab");
    send_text("xab");
    send_text(" ab.");
    send_text("ab_");
    wait_idle();

    // whole record must equal the literal
    program_matcher(p, 6'd2, 1'b0, 1'b1);
    send_text("ab");
    send_text("abc");
    wait_idle();

    while (items_sent < ITEM_GOAL) begin
      for (int r = 0; r < rlm_pkg::PAT_REGS; r++) begin
        for (int k = 0; k < 8; k++) p[r][k*8 +: 8] = text_byte();
        if ($urandom_range(0, 7) == 0) p[r] = {$urandom, $urandom};
      end
      case ($urandom_range(0, 9))
        0: plen = 6'd0;
        1: plen = 6'd1;
        2, 3, 4: plen = rlm_pkg::LEN_REG_W'($urandom_range(2, 6));
        5: plen = rlm_pkg::LEN_REG_W'($urandom_range(7, 31));
        6: plen = 6'd32;
        7: plen = 6'd63;
        8: plen = rlm_pkg::LEN_REG_W'($urandom_range(33, 62));
        default: plen = rlm_pkg::LEN_REG_W'($urandom_range(2, 4));
      endcase
      quiet_in = $urandom_range(0, 3) == 0;
      quiet_out = $urandom_range(0, 3) == 0;
      program_matcher(p, plen, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
      repeat ($urandom_range(4, 30)) send_random_record();
      wait_idle();
    end

    if (sb.errors == 0) begin
      $display("record_literal_matcher_tb: clean");
    end else begin
      $display("record_literal_matcher_tb: errors");
    end
    $finish;
  end

endmodule

[files.f]
src/rlm_pkg.sv
src/record_literal_matcher.sv
tb/sv/record_literal_matcher_tb.sv
